// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the occurrence counter table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

// ===== hw/rtl/ipoct_pkg.sv =====
// Package: controller states and command/status structs for the counter table.
`default_nettype none
package ipoct_pkg;
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HEAD_RD,
        ST_HEAD_WAIT,
        ST_CHECK,
        ST_ENT_WAIT,
        ST_UPDATE,
        ST_INSERT,
        ST_RESP
    } ctrl_state_t;

    typedef struct packed {
        logic load;       // capture input word
        logic head_rd;    // issue bucket head read
        logic take_head;  // current link <= head read data
        logic ent_rd;     // issue entry read at current link
        logic follow;     // current link <= next pointer of entry
        logic upd_hit;    // write incremented count/flags
        logic insert;     // write new entry and head
        logic set_full;   // result: table full
        logic set_zero;   // result: absent, count 0
        logic set_hit;    // result: entry count (query)
        logic clr_steps;  // clear walk step counter
    } dp_cmd_t;

    typedef struct packed {
        logic is_query;
        logic link_ok;    // current link valid and below step bound
        logic addr_eq;    // entry address matches key
        logic pool_full;
    } dp_stat_t;
endpackage
`default_nettype wire

// ===== hw/rtl/ip_occurrence_counter_table_top.sv =====
// Sequence: bucket head read, then one entry read per chain link examined; a store
// then does the update or insert before the result is presented.
// Throughput: one word at a time; next word accepted the cycle after the result is taken.
// Rate set by the one-read-per-link walk over the entry pool memories.
// Reset: synchronous active-low aresetn; then a sweep marks every bucket head
// empty, during which s_ready stays low.
`default_nettype none
module ip_occurrence_counter_table_top #(
    parameter int NUM_BUCKETS = 256,
    parameter int CAPACITY    = 1024
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire         s_func,
    input  wire  [31:0] s_ip_address,
    input  wire  [31:0] s_flag_bits,
    output logic        m_valid,
    input  wire         m_ready,
    output logic [31:0] m_hit_count,
    output logic        m_status
);
    import ipoct_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic     busy_clear;
    logic     ctrl_ready;
    logic     s_valid_gated;

    // hold off input words until the head clear sweep is done
    assign s_valid_gated = s_valid && !busy_clear;
    assign s_ready = ctrl_ready && !busy_clear;

    ipoct_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid_gated),
        .s_ready (ctrl_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    ipoct_dp #(
        .NUM_BUCKETS (NUM_BUCKETS),
        .CAPACITY    (CAPACITY)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .busy_clear   (busy_clear),
        .s_func       (s_func),
        .s_ip_address (s_ip_address),
        .s_flag_bits  (s_flag_bits),
        .m_hit_count  (m_hit_count),
        .m_status     (m_status)
    );
endmodule
`default_nettype wire

// ===== hw/rtl/ipoct_ctrl.sv =====
// Controller state machine for the counter table.
`default_nettype none
module ipoct_ctrl (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  wire                  m_ready,
    input  ipoct_pkg::dp_stat_t  stat,
    output ipoct_pkg::dp_cmd_t   cmd
);
    import ipoct_pkg::*;
    `include "assert_macros.svh"

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else state_reg <= state_next;
    end

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        s_ready = 1'b0;
        m_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load = 1'b1;
                    state_next = ST_HEAD_RD;
                end
            end
            ST_HEAD_RD: begin
                cmd.head_rd = 1'b1;
                state_next = ST_HEAD_WAIT;
            end
            ST_HEAD_WAIT: begin
                cmd.take_head = 1'b1;
                cmd.clr_steps = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (stat.link_ok) begin
                    cmd.ent_rd = 1'b1;
                    state_next = ST_ENT_WAIT;
                end else if (stat.is_query) begin
                    cmd.set_zero = 1'b1;
                    state_next = ST_RESP;
                end else begin
                    state_next = ST_INSERT;
                end
            end
            ST_ENT_WAIT: begin
                if (stat.addr_eq) begin
                    if (stat.is_query) begin
                        cmd.set_hit = 1'b1;
                        state_next = ST_RESP;
                    end else begin
                        state_next = ST_UPDATE;
                    end
                end else begin
                    cmd.follow = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_UPDATE: begin
                cmd.upd_hit = 1'b1;
                state_next = ST_RESP;
            end
            ST_INSERT: begin
                if (stat.pool_full) cmd.set_full = 1'b1;
                else cmd.insert = 1'b1;
                state_next = ST_RESP;
            end
            ST_RESP: begin
                m_valid = 1'b1;
                if (m_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    `ASSERT_IMPLY(a_ready_idle, aclk, aresetn, s_ready, !m_valid)
    `ASSERT_NEXT(a_load_walk, aclk, aresetn, s_valid && s_ready, state_reg == ST_HEAD_RD)
    `ASSERT_IMPLY(a_one_write, aclk, aresetn, cmd.upd_hit, !cmd.insert)
endmodule
`default_nettype wire

// ===== hw/rtl/ipoct_dp.sv =====
// Datapath: bucket heads, entry pool memories, key and result registers.
`default_nettype none
module ipoct_dp #(
    parameter int NUM_BUCKETS = 256,
    parameter int CAPACITY    = 1024
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  ipoct_pkg::dp_cmd_t   cmd,
    output ipoct_pkg::dp_stat_t  stat,
    output logic                 busy_clear,
    input  wire                  s_func,
    input  wire  [31:0]          s_ip_address,
    input  wire  [31:0]          s_flag_bits,
    output logic [31:0]          m_hit_count,
    output logic                 m_status
);
    import ipoct_pkg::*;
    `include "assert_macros.svh"

    localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int IW = $clog2(CAPACITY);
    localparam int LW = $clog2(CAPACITY + 1);
    localparam logic [LW-1:0] LINK_EMPTY = LW'(CAPACITY);

    // bucket heads are cleared by a sweep after reset; entries need no clear
    logic [LW-1:0] head_mem [NUM_BUCKETS];
    logic [31:0]   addr_mem [CAPACITY];
    logic [31:0]   cnt_mem  [CAPACITY];
    logic [31:0]   flg_mem  [CAPACITY];
    logic [LW-1:0] next_mem [CAPACITY];

    logic          func_reg;
    logic [31:0]   key_reg, flags_reg;
    logic [LW-1:0] link_reg, head_rd_reg, used_reg, steps_reg;
    logic [BW-1:0] clr_idx_reg;
    logic          clr_busy_reg;
    logic [31:0]   ra_reg, rc_reg, rf_reg;
    logic [LW-1:0] rn_reg;
    logic [31:0]   cnt_reg;
    logic          status_reg;
    logic [BW-1:0] bucket;
    logic [31:0]   cnt_inc;

    assign bucket = BW'(key_reg % 32'(NUM_BUCKETS));
    assign cnt_inc = (rc_reg == 32'hFFFF_FFFF) ? rc_reg : rc_reg + 32'd1;
    assign busy_clear = clr_busy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_idx_reg  <= '0;
            used_reg     <= '0;
        end else begin
            if (clr_busy_reg) begin
                head_mem[clr_idx_reg] <= LINK_EMPTY;
                clr_idx_reg <= clr_idx_reg + BW'(1);
                if (32'(clr_idx_reg) == NUM_BUCKETS - 1) clr_busy_reg <= 1'b0;
            end else if (cmd.insert) begin
                head_mem[bucket] <= used_reg;
            end
            if (cmd.insert) used_reg <= used_reg + LW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg  <= s_func;
            key_reg   <= s_ip_address;
            flags_reg <= s_flag_bits;
        end
        if (cmd.head_rd) head_rd_reg <= head_mem[bucket];
        if (cmd.take_head) link_reg <= head_rd_reg;
        if (cmd.follow) link_reg <= rn_reg;
        if (cmd.clr_steps) steps_reg <= '0;
        else if (cmd.follow) steps_reg <= steps_reg + LW'(1);
        if (cmd.ent_rd) begin
            ra_reg <= addr_mem[link_reg[IW-1:0]];
            rc_reg <= cnt_mem[link_reg[IW-1:0]];
            rf_reg <= flg_mem[link_reg[IW-1:0]];
            rn_reg <= next_mem[link_reg[IW-1:0]];
        end
        if (cmd.upd_hit) begin
            cnt_mem[link_reg[IW-1:0]] <= cnt_inc;
            flg_mem[link_reg[IW-1:0]] <= rf_reg | flags_reg;
            cnt_reg <= cnt_inc;
            status_reg <= 1'b0;
        end
        if (cmd.insert) begin
            addr_mem[used_reg[IW-1:0]] <= key_reg;
            cnt_mem[used_reg[IW-1:0]]  <= 32'd1;
            flg_mem[used_reg[IW-1:0]]  <= flags_reg;
            next_mem[used_reg[IW-1:0]] <= head_rd_reg;
            cnt_reg <= 32'd1;
            status_reg <= 1'b0;
        end
        if (cmd.set_full) begin
            cnt_reg <= '0;
            status_reg <= 1'b1;
        end
        if (cmd.set_zero) begin
            cnt_reg <= '0;
            status_reg <= 1'b0;
        end
        if (cmd.set_hit) begin
            cnt_reg <= rc_reg;
            status_reg <= 1'b0;
        end
    end

    always_comb begin
        stat.is_query  = func_reg;
        stat.link_ok   = (link_reg < used_reg) && (link_reg < LINK_EMPTY)
                         && (steps_reg < LINK_EMPTY);
        stat.addr_eq   = (ra_reg == key_reg);
        stat.pool_full = (used_reg >= LINK_EMPTY);
    end

    assign m_hit_count = cnt_reg;
    assign m_status    = status_reg;

    `ASSERT_IMPLY(a_used_bound, aclk, aresetn, 1'b1, used_reg <= LINK_EMPTY)
    `ASSERT_IMPLY(a_no_insert_full, aclk, aresetn, cmd.insert, !stat.pool_full)
    `ASSERT_NEXT(a_full_result, aclk, aresetn, cmd.set_full, m_status && (m_hit_count == '0))
endmodule
`default_nettype wire
